@@ src/wlpd_pkg.sv @@
package wlpd_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_NOISE_MARGIN     = 2'd2;
    localparam logic [1:0] REG_BACKGROUND_LEVEL = 2'd3;

    localparam int CFG_WIDTH = 12;
    localparam int COUNT_WIDTH = 23;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PLAN  = 6'b000010,
        ST_CNTR  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

endpackage

@@ src/window_local_peak_detector.sv @@
// Channel   Signals                                     Direction
// pixel     pixel_valid, pixel_ready, pixel             in
// result    result_valid, result_ready, is_peak,        out
//           center_col, center_row, peak_total,
//           bright_total, last_of_run, frame_done
// config    cfg_we, cfg_index, cfg_data                 in
//
// One request is written into the line memory in ST_IDLE; ST_PLAN works out the
// results it releases; in ST_CNTR and ST_SCAN the single read port of the line
// memory fetches the center and every window tap one per cycle.
// Up to (WINDOW/2+1)^2 results can follow one pixel at the bottom right corner.
// Reset clears the scan position and the counts and presets the config registers;
// the line memory holds no reset value. A stalled result holds the sequencer.
module window_local_peak_detector
    import wlpd_pkg::*;
#(
    parameter int WINDOW     = 7,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_ready,
    input  logic [7:0]             pixel,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   is_peak,
    output logic [10:0]            center_col,
    output logic [10:0]            center_row,
    output logic [COUNT_WIDTH-1:0] peak_total,
    output logic [COUNT_WIDTH-1:0] bright_total,
    output logic                   last_of_run,
    output logic                   frame_done
);

    localparam int HALF   = WINDOW / 2;
    localparam int SW     = $clog2(WINDOW);
    localparam int DEPTH  = WINDOW * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int OW     = $clog2(WINDOW + 1);
    localparam int GW     = CFG_WIDTH + 2;

    // Configuration registers.
    logic [CFG_WIDTH-1:0] width_reg, height_reg;
    logic [7:0]           margin_reg, background_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= CFG_WIDTH'(2048);
            height_reg     <= CFG_WIDTH'(2048);
            margin_reg     <= 8'd3;
            background_reg <= 8'd34;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:      width_reg <= cfg_data;
                REG_FRAME_HEIGHT:     height_reg <= cfg_data;
                REG_NOISE_MARGIN:     margin_reg <= cfg_data[7:0];
                REG_BACKGROUND_LEVEL: background_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective geometry, clamped to 1..MAX.
    logic [GW-1:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = GW'(width_reg);
        if (w_eff < GW'(1)) w_eff = GW'(1);
        if (w_eff > GW'(MAX_WIDTH)) w_eff = GW'(MAX_WIDTH);
        h_eff = GW'(height_reg);
        if (h_eff < GW'(1)) h_eff = GW'(1);
        if (h_eff > GW'(MAX_HEIGHT)) h_eff = GW'(MAX_HEIGHT);
    end

    // Control state.
    state_t state_reg, state_next;
    logic [GW-1:0] scan_col_reg, scan_row_reg;
    logic [SW-1:0] slot_reg;
    logic [COUNT_WIDTH-1:0] peak_count_reg, bright_count_reg;
    logic [GW-1:0] r_reg, r1_reg, c_reg, c0_reg, c1_reg;
    logic          fdone_reg;
    logic [OW-1:0] oi_reg, oj_reg;
    logic          tap_pend_reg, center_pend_reg, ok_reg;
    logic [7:0]    center_val_reg;

    // Line memory with one port, read data registered.
    logic [7:0]    mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= pixel;
        mem_q <= mem[mem_addr];
    end

    // Slot of a frame row in the circular store.
    function automatic logic [SW-1:0] slot_of(input logic [GW-1:0] row,
                                              input logic [GW-1:0] base_row,
                                              input logic [SW-1:0] base_slot);
        logic [GW:0] d;
        logic [GW:0] s;
        begin
            // Rows read lie within WINDOW-1 rows before the newest row, so one modular step suffices.
            d = {1'b0, base_row} - {1'b0, row};
            s = {{(GW+1-SW){1'b0}}, base_slot} + GW'(WINDOW) - d;
            if (s >= (GW+1)'(WINDOW)) s = s - (GW+1)'(WINDOW);
            slot_of = s[SW-1:0];
        end
    endfunction

    // Mirror then clamp one coordinate.
    function automatic logic [GW-1:0] mirror(input logic [GW-1:0] ctr,
                                             input logic [OW-1:0] o,
                                             input logic [GW-1:0] lim);
        logic signed [GW+1:0] off, p;
        begin
            off = $signed({{(GW+2-OW){1'b0}}, o}) - (GW+2)'(HALF);
            p = $signed({2'b00, ctr}) + off;
            if (p < 0 || p > $signed({2'b00, lim}) - 1)
                p = $signed({2'b00, ctr}) - off;
            if (p < 0) p = '0;
            if (p > $signed({2'b00, lim}) - 1) p = $signed({2'b00, lim}) - 1;
            mirror = p[GW-1:0];
        end
    endfunction

    // Newest written row, for the slot mapping during the judging.
    logic [GW-1:0] wrow_reg;
    logic [SW-1:0] wslot_reg;

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s,
                                              input logic [GW-1:0] c);
        logic [GW-1:0] cc;
        begin
            cc = (c < GW'(MAX_WIDTH)) ? c : GW'(MAX_WIDTH - 1);
            addr_of = AW'(s) * AW'(MAX_WIDTH) + AW'(cc);
        end
    endfunction

    logic [GW-1:0] tap_r, tap_c;
    logic          tap_center;
    assign tap_r = mirror(r_reg, oi_reg, h_eff);
    assign tap_c = mirror(c_reg, oj_reg, w_eff);
    assign tap_center = (oi_reg == OW'(HALF)) && (oj_reg == OW'(HALF));

    logic row_end, last_row;
    assign row_end  = scan_col_reg >= w_eff - GW'(1);
    assign last_row = scan_row_reg >= h_eff - GW'(1);

    // The accepted pixel releases at least one center.
    logic plan_go;
    assign plan_go = (last_row || scan_row_reg >= GW'(HALF)) &&
                     (row_end || scan_col_reg >= GW'(HALF));

    // Memory port steering.
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = addr_of(slot_reg, scan_col_reg);
        if (state_reg == ST_IDLE)
            mem_we = pixel_valid;
        else if (state_reg == ST_CNTR)
            mem_addr = addr_of(slot_of(r_reg, wrow_reg, wslot_reg), c_reg);
        else if (state_reg == ST_SCAN)
            mem_addr = addr_of(slot_of(tap_r, wrow_reg, wslot_reg), tap_c);
    end

    assign pixel_ready = (state_reg == ST_IDLE);

    // Result register.
    logic                   pk_reg, last_reg, fd_reg;
    logic [10:0]            ocol_reg, orow_reg;
    assign result_valid = (state_reg == ST_WAIT);
    assign is_peak      = pk_reg;
    assign center_col   = ocol_reg;
    assign center_row   = orow_reg;
    assign peak_total   = peak_count_reg;
    assign bright_total = bright_count_reg;
    assign last_of_run  = last_reg;
    assign frame_done   = fd_reg;

    logic more_cols, more_rows, bright_hit;
    assign more_cols  = c_reg < c1_reg;
    assign more_rows  = r_reg < r1_reg;
    assign bright_hit = center_val_reg >= background_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pixel_valid) state_next = ST_PLAN;
            ST_PLAN: state_next = plan_go ? ST_CNTR : ST_IDLE;
            ST_CNTR: state_next = ST_SCAN;
            ST_SCAN: if (!tap_pend_reg && oi_reg == OW'(WINDOW)) state_next = ST_EMIT;
            ST_EMIT: state_next = ST_WAIT;
            ST_WAIT: if (result_ready)
                         state_next = (more_cols || more_rows) ? ST_CNTR : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_col_reg     <= '0;
            scan_row_reg     <= '0;
            slot_reg         <= '0;
            peak_count_reg   <= '0;
            bright_count_reg <= '0;
            fdone_reg        <= 1'b0;
            tap_pend_reg     <= 1'b0;
            center_pend_reg  <= 1'b0;
            ok_reg           <= 1'b0;
            oi_reg           <= '0;
            oj_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                // Pixel written; work out the range of centers it releases.
                ST_IDLE:
                begin
                    if (pixel_valid)
                    begin
                        wrow_reg  <= scan_row_reg;
                        wslot_reg <= slot_reg;
                    end
                end
                ST_PLAN:
                begin
                    logic hr, hc;
                    logic [GW-1:0] rr0, rr1, cc0, cc1;
                    if (last_row)
                    begin
                        rr0 = (h_eff - GW'(1) >= GW'(HALF)) ? h_eff - GW'(1 + HALF) : '0;
                        rr1 = h_eff - GW'(1);
                        hr  = 1'b1;
                    end
                    else
                    begin
                        hr  = scan_row_reg >= GW'(HALF);
                        rr0 = hr ? scan_row_reg - GW'(HALF) : scan_row_reg;
                        rr1 = rr0;
                    end
                    if (row_end)
                    begin
                        cc0 = (w_eff - GW'(1) >= GW'(HALF)) ? w_eff - GW'(1 + HALF) : '0;
                        cc1 = w_eff - GW'(1);
                        hc  = 1'b1;
                    end
                    else
                    begin
                        hc  = scan_col_reg >= GW'(HALF);
                        cc0 = hc ? scan_col_reg - GW'(HALF) : scan_col_reg;
                        cc1 = cc0;
                    end
                    r_reg  <= rr0;
                    r1_reg <= rr1;
                    c_reg  <= cc0;
                    c0_reg <= cc0;
                    c1_reg <= cc1;
                    fdone_reg <= row_end && last_row;
                    // Advance the scan.
                    if (row_end)
                    begin
                        scan_col_reg <= '0;
                        if (last_row)
                        begin
                            scan_row_reg <= '0;
                            slot_reg     <= '0;
                        end
                        else
                        begin
                            scan_row_reg <= scan_row_reg + GW'(1);
                            slot_reg <= (slot_reg == SW'(WINDOW - 1)) ? '0 : slot_reg + SW'(1);
                        end
                    end
                    else
                        scan_col_reg <= scan_col_reg + GW'(1);
                    center_pend_reg <= 1'b1;
                    oi_reg <= '0;
                    oj_reg <= '0;
                    ok_reg <= 1'b1;
                end
                // Center read issued; taps follow one per cycle.
                ST_CNTR:
                begin
                    center_pend_reg <= 1'b1;
                    tap_pend_reg    <= 1'b0;
                    oi_reg <= '0;
                    oj_reg <= '0;
                    ok_reg <= 1'b1;
                end
                ST_SCAN:
                begin
                    if (center_pend_reg)
                    begin
                        center_val_reg  <= mem_q;
                        center_pend_reg <= 1'b0;
                    end
                    else if (tap_pend_reg)
                    begin
                        if ({1'b0, mem_q} + {1'b0, margin_reg} > {1'b0, center_val_reg})
                            ok_reg <= 1'b0;
                    end
                    if (oi_reg != OW'(WINDOW))
                    begin
                        tap_pend_reg <= !tap_center;
                        if (oj_reg == OW'(WINDOW - 1))
                        begin
                            oj_reg <= '0;
                            oi_reg <= oi_reg + OW'(1);
                        end
                        else
                            oj_reg <= oj_reg + OW'(1);
                    end
                    else
                        tap_pend_reg <= 1'b0;
                end
                ST_EMIT:
                begin
                    pk_reg   <= ok_reg;
                    ocol_reg <= c_reg[10:0];
                    orow_reg <= r_reg[10:0];
                    last_reg <= !(more_cols || more_rows);
                    fd_reg   <= fdone_reg && !(more_cols || more_rows);
                    if (ok_reg && peak_count_reg != COUNT_MAX)
                        peak_count_reg <= peak_count_reg + COUNT_WIDTH'(1);
                    if (bright_hit && bright_count_reg != COUNT_MAX)
                        bright_count_reg <= bright_count_reg + COUNT_WIDTH'(1);
                end
                ST_WAIT:
                begin
                    if (result_ready)
                    begin
                        if (more_cols)
                            c_reg <= c_reg + GW'(1);
                        else if (more_rows)
                        begin
                            c_reg <= c0_reg;
                            r_reg <= r_reg + GW'(1);
                        end
                        else if (fd_reg)
                        begin
                            peak_count_reg   <= '0;
                            bright_count_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ verif/window_local_peak_detector_tb.sv @@
module window_local_peak_detector_tb;
    import wlpd_pkg::*;

    localparam int WIN        = 7;
    localparam int HALF_WIN   = WIN / 2;
    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 2048;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 80;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic                   is_peak;
        logic [10:0]            col;
        logic [10:0]            row;
        logic [COUNT_WIDTH-1:0] peaks;
        logic [COUNT_WIDTH-1:0] brights;
        logic                   last;
        logic                   done;
    } peak_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = REG_FRAME_WIDTH;
    logic [CFG_WIDTH-1:0]   cfg_data = '0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_ready;
    logic [7:0]             pixel = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   is_peak;
    logic [10:0]            center_col;
    logic [10:0]            center_row;
    logic [COUNT_WIDTH-1:0] peak_total;
    logic [COUNT_WIDTH-1:0] bright_total;
    logic                   last_of_run;
    logic                   frame_done;

    // Predictor state: line memory copy, scan position, counts, registers.
    logic [7:0]   pixel_rows [0:WIN*MAX_W-1];
    int unsigned  scan_x = 0;
    int unsigned  scan_y = 0;
    int unsigned  peak_cnt = 0;
    int unsigned  bright_cnt = 0;
    logic [11:0]  width_reg = 12'd2048;
    logic [11:0]  height_reg = 12'd2048;
    logic [7:0]   margin_reg = 8'd3;
    logic [7:0]   level_reg = 8'd34;

    peak_result_t pending_results[$];
    int           failures = 0;
    int           pixels_sent = 0;
    bit           steady_flow = 1'b0;
    bit           long_hold_req = 1'b0;

    window_local_peak_detector u_top (.*);

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Line memory lookup with the column clamped to the memory width.
    function automatic int stored_px(int r, int c);
        return pixel_rows[(r % WIN) * MAX_W + (c < MAX_W ? c : MAX_W - 1)];
    endfunction

    // Reflect a window tap about the center, then clamp into the frame.
    function automatic int reflect_tap(int center, int off, int lim);
        int p;
        p = center + off;
        if (p < 0 || p > lim - 1)
            p = center - off;
        if (p < 0)
            p = 0;
        if (p > lim - 1)
            p = lim - 1;
        return p;
    endfunction

    function automatic bit is_local_peak(int r, int c, int w, int h);
        int ctr;
        ctr = stored_px(r, c);
        for (int i = -HALF_WIN; i <= HALF_WIN; i++)
            for (int j = -HALF_WIN; j <= HALF_WIN; j++)
                if (!(i == 0 && j == 0))
                    if (stored_px(reflect_tap(r, i, h), reflect_tap(c, j, w))
                        + margin_reg > ctr)
                        return 1'b0;
        return 1'b1;
    endfunction

    // Work out every result that one accepted pixel releases.
    task automatic predict_centers(input logic [7:0] value);
        int w, h, r0, r1, c0, c1, first;
        bit row_end, last_row, have_rows, have_cols;
        peak_result_t res;
        w = (width_reg < 1) ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
        h = (height_reg < 1) ? 1 : (height_reg > MAX_H ? MAX_H : height_reg);
        row_end = scan_x >= w - 1;
        last_row = scan_y >= h - 1;
        pixel_rows[(scan_y % WIN) * MAX_W + (scan_x < MAX_W ? scan_x : MAX_W - 1)] = value;
        if (last_row)
        begin
            r0 = (h - 1 >= HALF_WIN) ? h - 1 - HALF_WIN : 0;
            r1 = h - 1;
            have_rows = 1'b1;
        end
        else
        begin
            have_rows = scan_y >= HALF_WIN;
            r0 = have_rows ? scan_y - HALF_WIN : scan_y;
            r1 = r0;
        end
        if (row_end)
        begin
            c0 = (w - 1 >= HALF_WIN) ? w - 1 - HALF_WIN : 0;
            c1 = w - 1;
            have_cols = 1'b1;
        end
        else
        begin
            have_cols = scan_x >= HALF_WIN;
            c0 = have_cols ? scan_x - HALF_WIN : scan_x;
            c1 = c0;
        end
        first = pending_results.size();
        if (have_rows && have_cols)
            for (int r = r0; r <= r1; r++)
                for (int c = c0; c <= c1; c++)
                begin
                    res.is_peak = is_local_peak(r, c, w, h);
                    if (res.is_peak && peak_cnt < COUNT_MAX)
                        peak_cnt++;
                    if (stored_px(r, c) >= level_reg && bright_cnt < COUNT_MAX)
                        bright_cnt++;
                    res.col = c[10:0];
                    res.row = r[10:0];
                    res.peaks = peak_cnt[COUNT_WIDTH-1:0];
                    res.brights = bright_cnt[COUNT_WIDTH-1:0];
                    res.last = 1'b0;
                    res.done = 1'b0;
                    pending_results.push_back(res);
                end
        if (pending_results.size() > first)
        begin
            pending_results[$].last = 1'b1;
            pending_results[$].done = row_end && last_row;
        end
        if (row_end)
        begin
            scan_x = 0;
            if (last_row)
            begin
                scan_y = 0;
                peak_cnt = 0;
                bright_cnt = 0;
            end
            else
                scan_y++;
        end
        else
            scan_x++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one pixel request and wait for it to be taken.
    task automatic send_pixel(input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= value;
        do
            @(posedge clk);
        while (!(pixel_valid && pixel_ready));
        predict_centers(value);
        pixels_sent++;
    endtask

    // Drop valid, drain all results, then let the sequencer settle.
    task automatic drain_block();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles; the block is idle here.
    task automatic set_config(input int w, input int h, input int m, input int lvl);
        logic [CFG_WIDTH-1:0] vals [4];
        vals[REG_FRAME_WIDTH] = CFG_WIDTH'(w);
        vals[REG_FRAME_HEIGHT] = CFG_WIDTH'(h);
        vals[REG_NOISE_MARGIN] = CFG_WIDTH'(m);
        vals[REG_BACKGROUND_LEVEL] = CFG_WIDTH'(lvl);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        width_reg = vals[REG_FRAME_WIDTH];
        height_reg = vals[REG_FRAME_HEIGHT];
        margin_reg = vals[REG_NOISE_MARGIN][7:0];
        level_reg = vals[REG_BACKGROUND_LEVEL][7:0];
        @(posedge clk);
    endtask

    // A 4x4 frame, one bright spot among black, widest margin.
    task automatic test_extreme_levels();
        set_config(4, 4, 255, 255);
        for (int i = 0; i < 16; i++)
            send_pixel(i == 5 ? 8'd255 : 8'd0);
        drain_block();
    endtask

    // With no margin a flat row makes every center a peak.
    task automatic test_zero_margin();
        set_config(4, 1, 0, 0);
        repeat (4) send_pixel(8'd128);
        drain_block();
    endtask

    // Zero geometry clamps to a one-pixel frame whose taps all land on the center.
    task automatic test_tiny_frames();
        set_config(0, 0, 1, 128);
        send_pixel(8'd0);
        send_pixel(8'd255);
        drain_block();
    endtask

    // Random small frames with sparse bright spots; the first one is backpressured.
    task automatic test_random_frames();
        int w, h, start_count, frame_no;
        start_count = pixels_sent;
        frame_no = 0;
        while (pixels_sent - start_count < 85)
        begin
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 9);
            set_config(w, h,
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 10),
                       $urandom_range(0, 255));
            steady_flow = (frame_no % 4 == 3);
            if (frame_no == 0)
                long_hold_req = 1'b1;
            for (int i = 0; i < w * h; i++)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_pixel(8'($urandom_range(0, 255)));
                else
                    send_pixel(8'($urandom_range(0, 40)));
            end
            drain_block();
            frame_no++;
        end
        steady_flow = 1'b0;
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    int stall_left = 0;
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (steady_flow)
            result_ready <= 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                result_ready <= 1'b1;
            else if (r < 95)
            begin
                result_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                result_ready <= 1'b0;
                stall_left = $urandom_range(10, 60);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        peak_result_t got, want;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{is_peak, center_col, center_row, peak_total, bright_total,
                    last_of_run, frame_done};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch expected %p actual %p", $time, want, got);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on either channel.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < WIN * MAX_W; i++)
            pixel_rows[i] = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_levels();
        test_zero_margin();
        test_tiny_frames();
        test_random_frames();
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ window_local_peak_detector.f @@
src/wlpd_pkg.sv
src/window_local_peak_detector.sv
verif/window_local_peak_detector_tb.sv
